// ===== sv/wse_pkg.sv =====
// types and constants shared by the wiggle sort engine
// no dependencies; imported by every module of the block
package wse_pkg;

    localparam int DATA_W = 32;

    // configuration register map (word indices on the register port, matched against paddr[3:2])
    localparam int          PADDR_W   = 4;
    localparam logic [1:0]  REG_MODE  = 2'd0;
    localparam logic        MODE_DOWN = 1'b0;
    localparam logic        MODE_UP   = 1'b1;

    // payload of one input transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    // payload of one result transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     dropped;
    } res_t;

    // what one sorting stage shows its neighbours
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     vld;
        logic                     lt;
    } cell_link_t;

    localparam cell_link_t LINK_NONE = '0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/wse_cell.sv =====
// one stage of the insertion chain: holds a single sorted element
// depends on wse_pkg
module wse_cell
    import wse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] ins_value,
    input  logic                     ins_en,
    input  logic                     shift,
    input  cell_link_t               left,
    input  cell_link_t               right,
    output cell_link_t               link
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     vld_reg;
    logic                     vld_next;
    logic                     lt;

    // new value goes at or before this slot
    assign lt = !vld_reg || (ins_value < val_reg);

    assign link.value = val_reg;
    assign link.vld   = vld_reg;
    assign link.lt    = lt;

    // insert, ripple right, or drain towards the head
    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (shift)
        begin
            val_next = right.value;
            vld_next = right.vld;
        end
        else if (ins_en && lt)
        begin
            val_next = left.lt ? left.value : ins_value;
            vld_next = left.lt ? left.vld : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== sv/wse_chain.sv =====
// row of sorting stages kept in ascending order, head at stage 0
// depends on wse_pkg and wse_cell
module wse_chain
    import wse_pkg::*;
#(
    parameter int MAX_ELEMS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] ins_value,
    input  logic                     ins_en,
    input  logic                     shift,
    output logic signed [DATA_W-1:0] head
);

    cell_link_t lnk [MAX_ELEMS];

    // one stage per element, each linked to both neighbours
    for (genvar g = 0; g < MAX_ELEMS; g++)
    begin : g_stage
        cell_link_t left_lnk;
        cell_link_t right_lnk;

        if (g == 0)
        begin : g_first
            assign left_lnk = LINK_NONE;
        end
        else
        begin : g_mid
            assign left_lnk = lnk[g-1];
        end

        if (g == MAX_ELEMS - 1)
        begin : g_end
            assign right_lnk = LINK_NONE;
        end
        else
        begin : g_inner
            assign right_lnk = lnk[g+1];
        end

        wse_cell u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ins_value (ins_value),
            .ins_en    (ins_en),
            .shift     (shift),
            .left      (left_lnk),
            .right     (right_lnk),
            .link      (lnk[g])
        );
    end

    assign head = lnk[0].value;

endmodule

// ===== sv/wse_emit.sv =====
// sorted buffer and wiggle-order read-out with a two-entry output queue
// depends on wse_pkg
module wse_emit
    import wse_pkg::*;
#(
    parameter int MAX_ELEMS = 64,
    parameter int AW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
    parameter int CW        = $clog2(MAX_ELEMS + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     start,
    input  logic [CW-1:0]            n,
    input  logic                     mode,
    input  logic                     drop_flag,
    output logic                     busy,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_t                     res
);

    logic signed [DATA_W-1:0] mem [MAX_ELEMS];

    logic                     active_reg;
    logic                     active_next;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            i_reg;
    logic [CW-1:0]            lo_reg;
    logic [CW-1:0]            hi_reg;
    logic [CW-1:0]            lo_next;
    logic [CW-1:0]            hi_next;
    logic                     mode_reg;
    logic                     drop_reg;
    logic                     pend_reg;
    logic                     pend_last_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    res_t                     ent_reg [2];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;
    logic [CW:0]              mid_wide;
    logic [CW-1:0]            mid;
    logic [CW-1:0]            idx;
    logic [2:0]               occ;
    logic                     pop;
    logic                     issue;
    logic                     is_last;

    assign mid_wide = ({1'b0, n} + {{CW{1'b0}}, 1'b1}) >> 1;
    assign mid      = mid_wide[CW-1:0];

    // queue occupancy, counting the read still in flight
    assign pop   = res_valid && !res_stall;
    assign occ   = {1'b0, cnt_reg} + {2'b00, pend_reg};
    assign issue = active_reg && ((occ < 3'd2) || ((occ == 3'd2) && pop));

    assign is_last = (i_reg == n_reg - {{(CW-1){1'b0}}, 1'b1});

    // index of the next element: lower half on even, upper half on odd
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (mode_reg == MODE_DOWN)
        begin
            if (!i_reg[0])
            begin
                lo_next = lo_reg - {{(CW-1){1'b0}}, 1'b1};
                idx     = lo_next;
            end
            else
            begin
                hi_next = hi_reg - {{(CW-1){1'b0}}, 1'b1};
                idx     = hi_next;
            end
        end
        else
        begin
            if (!i_reg[0])
            begin
                idx     = lo_reg;
                lo_next = lo_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            else
            begin
                idx     = hi_reg;
                hi_next = hi_reg + {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        if (start)
        begin
            active_next = 1'b1;
        end
        else if (issue && is_last)
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (pend_reg && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!pend_reg && pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // sorted buffer: filled while the chain drains, read in wiggle order
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx[AW-1:0]];
        end
    end

    // read-out counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= issue;
            cnt_reg    <= cnt_next;
            if (pend_reg)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // per-array settings, index pointers and queue entry writes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= n;
            i_reg    <= '0;
            mode_reg <= mode;
            drop_reg <= drop_flag;
            if (mode == MODE_DOWN)
            begin
                lo_reg <= mid;
                hi_reg <= n;
            end
            else
            begin
                lo_reg <= '0;
                hi_reg <= mid;
            end
        end
        else if (issue)
        begin
            i_reg  <= i_reg + {{(CW-1){1'b0}}, 1'b1};
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (issue)
        begin
            pend_last_reg <= is_last;
        end
        if (pend_reg)
        begin
            ent_reg[wr_ptr_reg] <= '{value_res: rd_data_reg,
                                     last_res:  pend_last_reg,
                                     dropped:   drop_reg};
        end
    end

    assign res_valid = (cnt_reg != 2'd0);
    assign res       = ent_reg[rd_ptr_reg];
    assign busy      = active_reg || pend_reg || (cnt_reg != 2'd0);

endmodule

// ===== sv/wiggle_sort_engine.sv =====
// wiggle sort engine top level: load control, register port, read-out
// depends on wse_pkg, wse_chain and wse_emit
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-----------------------------
//  item     | in        | item_valid/stall  | item_t  (value, last)
//  res      | out       | res_valid/stall   | res_t   (value_res, last_res,
//           |           |                   |          dropped)
//  register | in/out    | psel/penable      | interleave_mode at byte 0
//
// loading takes one element per cycle into the insertion chain; the chain
// then drains into the buffer and the n results leave at up to one per
// cycle; the next item is taken only once the last result has left.
// reset clears the chain, counters and mode; no item is taken while an
// array drains or is read out, and a stalled result simply holds the queue.
module wiggle_sort_engine
    import wse_pkg::*;
#(
    parameter int MAX_ELEMS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);

    state_t        state_reg;
    state_t        state_next;
    logic          mode_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] drain_reg;
    logic          ovf_reg;
    logic          accept;
    logic          full;
    logic          ins_en;
    logic          drain_en;
    logic          drain_done;
    logic          start;
    logic          busy;
    logic          reg_wr;
    logic signed [DATA_W-1:0] head;

    assign full       = (count_reg == CW'(MAX_ELEMS));
    assign accept     = item_valid && !item_stall;
    assign ins_en     = accept && !full;
    assign drain_done = (drain_reg == count_reg - {{(CW-1){1'b0}}, 1'b1});

    // register port
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;
    assign prdata = (paddr[PADDR_W-1:2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DOWN;
        end
        else if (reg_wr && (paddr[PADDR_W-1:2] == REG_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && item.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        drain_en   = 1'b0;
        start      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                item_stall = 1'b0;
            end
            ST_DRAIN:
            begin
                drain_en = 1'b1;
                start    = drain_done;
            end
            ST_EMIT:
            begin
                item_stall = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // state, element count, overflow flag and drain pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drain_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ins_en)
            begin
                count_reg <= count_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            else if (start)
            begin
                count_reg <= '0;
            end
            if (accept && full)
            begin
                ovf_reg <= 1'b1;
            end
            else if (start)
            begin
                ovf_reg <= 1'b0;
            end
            if (start)
            begin
                drain_reg <= '0;
            end
            else if (drain_en)
            begin
                drain_reg <= drain_reg + {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    wse_chain #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ins_value (item.value),
        .ins_en    (ins_en),
        .shift     (drain_en),
        .head      (head)
    );

    wse_emit #(
        .MAX_ELEMS (MAX_ELEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (drain_en),
        .wr_addr   (drain_reg[AW-1:0]),
        .wr_data   (head),
        .start     (start),
        .n         (count_reg),
        .mode      (mode_reg),
        .drop_flag (ovf_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
